// File: design/bfbc_pkg.sv
// shared types and constants for the buddy free block coalescer
package bfbc_pkg;

    localparam int FRAME_W          = 12;
    localparam int ORDER_OUT_W      = 4;
    localparam int COUNT_W          = 13;
    localparam int WIDE_W           = 21;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 32;
    localparam int FRAME_COUNT_DEF  = 4096;
    localparam int ORDER_LEVELS_DEF = 11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic                can_try;
        logic [WIDE_W-1:0]   buddy;
        logic [FRAME_W-1:0]  merged_leader;
    } step_t;

    typedef struct packed {
        logic inc;
        logic dec;
    } cnt_op_t;

endpackage

// File: design/bfbc_mark_ram.sv
// single-port free-mark memory with registered read data
module bfbc_mark_ram #(
    parameter int DEPTH = bfbc_pkg::FRAME_COUNT_DEF,
    parameter int AW    = 12,
    parameter int DW    = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: design/bfbc_step_unit.sv
// shared buddy step unit: buddy index, zone bound and top order checks
module bfbc_step_unit #(
    parameter int FRAME_COUNT  = bfbc_pkg::FRAME_COUNT_DEF,
    parameter int ORDER_LEVELS = bfbc_pkg::ORDER_LEVELS_DEF,
    parameter int OW           = 4
) (
    input  logic [bfbc_pkg::FRAME_W-1:0] leader,
    input  logic [OW-1:0]                order,
    output bfbc_pkg::step_t              step
);

    logic [bfbc_pkg::WIDE_W-1:0] bit_mask;
    logic [bfbc_pkg::WIDE_W-1:0] leader_wide;
    logic [bfbc_pkg::WIDE_W-1:0] order_plus;

    always_comb begin
        bit_mask    = bfbc_pkg::WIDE_W'(1) << order;
        leader_wide = bfbc_pkg::WIDE_W'(leader);
        order_plus  = bfbc_pkg::WIDE_W'(order) + bfbc_pkg::WIDE_W'(1);
        step.buddy  = leader_wide ^ bit_mask;
        step.can_try = (order_plus < bfbc_pkg::WIDE_W'(ORDER_LEVELS)) &&
                       (step.buddy < bfbc_pkg::WIDE_W'(FRAME_COUNT));
        step.merged_leader = leader & ~bit_mask[bfbc_pkg::FRAME_W-1:0];
    end

endmodule

// File: design/bfbc_count_file.sv
// per-order free block counters with one shared saturating up/down adder
module bfbc_count_file #(
    parameter int ORDER_LEVELS = bfbc_pkg::ORDER_LEVELS_DEF,
    parameter int OW           = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [OW-1:0]                idx,
    input  bfbc_pkg::cnt_op_t            op,
    output logic [bfbc_pkg::COUNT_W-1:0] cnt_new
);

    logic [bfbc_pkg::COUNT_W-1:0] cnt_reg [ORDER_LEVELS];
    logic [bfbc_pkg::COUNT_W-1:0] cur;
    logic [bfbc_pkg::COUNT_W-1:0] delta;
    logic                         hold;

    always_comb begin
        cur     = cnt_reg[idx];
        delta   = op.dec ? bfbc_pkg::COUNT_MAX : bfbc_pkg::COUNT_W'(1);
        hold    = (op.dec && cur == '0) || (!op.dec && cur == bfbc_pkg::COUNT_MAX);
        cnt_new = hold ? cur : cur + delta;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ORDER_LEVELS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (op.inc || op.dec) begin
            cnt_reg[idx] <= cnt_new;
        end
    end

endmodule

// File: design/buddy_free_block_coalescer_unit.sv
// buddy free block coalescer top level: merge sequencer and result register
// sequence: each merge takes a probe and a check, reading and then clearing a buddy mark on
// the single mark memory port; the chain ends in an insert when a probe cannot try or a
// buddy read misses; one request at a time, and a result waits in its own register
// reset: counters clear at once, then a clearing pass writes every mark entry, with
// s_tready low until it ends
module buddy_free_block_coalescer_unit #(
    parameter int FRAME_COUNT  = bfbc_pkg::FRAME_COUNT_DEF,
    parameter int ORDER_LEVELS = bfbc_pkg::ORDER_LEVELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfbc_pkg::S_TDATA_W-1:0] s_tdata,   // frame_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bfbc_pkg::M_TDATA_W-1:0] m_tdata    // block_start, block_order, order_free_count
);

    localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int OW = (ORDER_LEVELS > 1) ? $clog2(ORDER_LEVELS) : 1;
    localparam int MW = $clog2(ORDER_LEVELS + 1);
    localparam int OUT_W = bfbc_pkg::FRAME_W + bfbc_pkg::ORDER_OUT_W + bfbc_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_INSERT,
        ST_REJECT
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic [bfbc_pkg::FRAME_W-1:0]    leader_reg, leader_next;
    logic [OW-1:0]                   order_reg, order_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [bfbc_pkg::FRAME_W-1:0]    start_reg, start_next;
    logic [bfbc_pkg::ORDER_OUT_W-1:0] ord_out_reg, ord_out_next;
    logic [bfbc_pkg::COUNT_W-1:0]    cnt_out_reg, cnt_out_next;

    bfbc_pkg::step_t                 step;
    bfbc_pkg::cnt_op_t               cnt_op;
    logic [bfbc_pkg::COUNT_W-1:0]    cnt_new;

    logic                            ram_we, ram_re;
    logic [AW-1:0]                   ram_addr;
    logic [MW-1:0]                   ram_wdata, ram_rdata;
    logic [MW-1:0]                   mark_cur;
    logic [bfbc_pkg::WIDE_W-1:0]     in_wide;
    logic [bfbc_pkg::WIDE_W-1:0]     leader_wide;
    logic                            out_free;
    logic                            match;

    bfbc_mark_ram #(
        .DEPTH (FRAME_COUNT),
        .AW    (AW),
        .DW    (MW)
    ) u_mark_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bfbc_step_unit #(
        .FRAME_COUNT  (FRAME_COUNT),
        .ORDER_LEVELS (ORDER_LEVELS),
        .OW           (OW)
    ) u_step_unit (
        .leader (leader_reg),
        .order  (order_reg),
        .step   (step)
    );

    bfbc_count_file #(
        .ORDER_LEVELS (ORDER_LEVELS),
        .OW           (OW)
    ) u_count_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .idx     (order_reg),
        .op      (cnt_op),
        .cnt_new (cnt_new)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(bfbc_pkg::M_TDATA_W - OUT_W){1'b0}},
                       cnt_out_reg, ord_out_reg, start_reg};

    always_comb begin
        in_wide     = bfbc_pkg::WIDE_W'(s_tdata[bfbc_pkg::FRAME_W-1:0]);
        leader_wide = bfbc_pkg::WIDE_W'(leader_reg);
        mark_cur    = MW'(order_reg) + MW'(1);
        out_free    = !m_tvalid_reg || m_tready;
        match       = (ram_rdata == mark_cur);

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        leader_next   = leader_reg;
        order_next    = order_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        start_next    = start_reg;
        ord_out_next  = ord_out_reg;
        cnt_out_next  = cnt_out_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = step.buddy[AW-1:0];
        ram_wdata = '0;
        cnt_op    = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(FRAME_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    leader_next = s_tdata[bfbc_pkg::FRAME_W-1:0];
                    order_next  = '0;
                    state_next  = (in_wide < bfbc_pkg::WIDE_W'(FRAME_COUNT)) ?
                                  ST_PROBE : ST_REJECT;
                end
            end
            ST_PROBE: begin
                if (step.can_try) begin
                    ram_re     = 1'b1;
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_CHECK: begin
                if (match) begin
                    ram_we      = 1'b1;
                    cnt_op.dec  = 1'b1;
                    leader_next = step.merged_leader;
                    order_next  = order_reg + OW'(1);
                    state_next  = ST_PROBE;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    ram_we        = 1'b1;
                    ram_addr      = leader_wide[AW-1:0];
                    ram_wdata     = mark_cur;
                    cnt_op.inc    = 1'b1;
                    m_tvalid_next = 1'b1;
                    start_next    = leader_reg;
                    ord_out_next  = bfbc_pkg::ORDER_OUT_W'(order_reg);
                    cnt_out_next  = cnt_new;
                    state_next    = ST_IDLE;
                end
            end
            ST_REJECT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    start_next    = leader_reg;
                    ord_out_next  = '0;
                    cnt_out_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            leader_reg   <= '0;
            order_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            start_reg    <= '0;
            ord_out_reg  <= '0;
            cnt_out_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            leader_reg   <= leader_next;
            order_reg    <= order_next;
            m_tvalid_reg <= m_tvalid_next;
            start_reg    <= start_next;
            ord_out_reg  <= ord_out_next;
            cnt_out_reg  <= cnt_out_next;
        end
    end

    // a new result only comes out of the insert or reject step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_INSERT || $past(state_reg) == ST_REJECT))
        else $error("result raised outside insert or reject");

    // an accepted request starts a probe or a reject
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PROBE || state_reg == ST_REJECT))
        else $error("request not followed by probe or reject");

    // a merge raises the order by exactly one and goes back to probe
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && match) |=>
            (order_reg == $past(order_reg) + OW'(1) && state_reg == ST_PROBE))
        else $error("merge did not advance the order");

endmodule

// File: test/coalesce_checker.sv
// checker for the buddy coalescer: mirrors free marks and order counts, compares each result
module coalesce_checker #(
    parameter int FRAME_COUNT  = bfbc_pkg::FRAME_COUNT_DEF,
    parameter int ORDER_LEVELS = bfbc_pkg::ORDER_LEVELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bfbc_pkg::S_TDATA_W-1:0] s_tdata,   // frame_index
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bfbc_pkg::M_TDATA_W-1:0] m_tdata,   // block_start, block_order, order_free_count
    output int unsigned                    fail_count,
    output int unsigned                    waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import bfbc_pkg::*;

    localparam int PAD_W = M_TDATA_W - FRAME_W - ORDER_OUT_W - COUNT_W;

    typedef struct packed {
        logic [PAD_W-1:0]       pad;
        logic [COUNT_W-1:0]     order_free_count;
        logic [ORDER_OUT_W-1:0] block_order;
        logic [FRAME_W-1:0]     block_start;
    } free_block_t;

    logic [ORDER_OUT_W-1:0] lead_mark [FRAME_COUNT];
    logic [COUNT_W-1:0]     order_tally [ORDER_LEVELS];
    free_block_t            blocks_due [$];

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        if (fail_count < 100)
            $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // walks the buddy chain upward, then marks and counts the final block; a frame out of range returns as it is
    function automatic free_block_t coalesce_free(input logic [FRAME_W-1:0] frame);
        free_block_t blk;
        int unsigned leader;
        int unsigned lvl;
        int unsigned buddy;
        blk    = '0;
        leader = frame;
        lvl    = 0;
        if (leader >= FRAME_COUNT) begin
            blk.block_start = frame;
            return blk;
        end
        while (lvl + 1 < ORDER_LEVELS) begin
            buddy = leader ^ (1 << lvl);
            if (buddy >= FRAME_COUNT)
                break;
            if (lead_mark[buddy] != ORDER_OUT_W'(lvl + 1))
                break;
            lead_mark[buddy] = '0;
            if (order_tally[lvl] != '0)
                order_tally[lvl] = order_tally[lvl] - 1'b1;
            leader = leader & ~(1 << lvl);
            lvl++;
        end
        lead_mark[leader] = ORDER_OUT_W'(lvl + 1);
        if (order_tally[lvl] != COUNT_MAX)
            order_tally[lvl] = order_tally[lvl] + 1'b1;
        blk.block_start      = FRAME_W'(leader);
        blk.block_order      = ORDER_OUT_W'(lvl);
        blk.order_free_count = order_tally[lvl];
        return blk;
    endfunction

    always @(posedge aclk) begin
        free_block_t got;
        free_block_t want;
        if (!aresetn) begin
            foreach (lead_mark[i]) lead_mark[i] = '0;
            foreach (order_tally[i]) order_tally[i] = '0;
            blocks_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (blocks_due.size() == 0) begin
                    log_mismatch("result with none pending, tdata", m_tdata, 0);
                end else begin
                    want = blocks_due.pop_front();
                    if (got.block_start != want.block_start)
                        log_mismatch("block_start", got.block_start, want.block_start);
                    if (got.block_order != want.block_order)
                        log_mismatch("block_order", got.block_order, want.block_order);
                    if (got.order_free_count != want.order_free_count)
                        log_mismatch("order_free_count", got.order_free_count,
                                     want.order_free_count);
                end
            end
            if (s_tvalid && s_tready)
                blocks_due.push_back(coalesce_free(s_tdata[FRAME_W-1:0]));
        end
        waiting = blocks_due.size();
    end

endmodule

// File: test/buddy_free_block_coalescer_unit_tb.sv
// testbench top for the buddy coalescer: request stimulus, result stalls and the verdict
module buddy_free_block_coalescer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfbc_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int LOW_HALF     = FRAME_COUNT_DEF / 2;
    localparam int TAIL_LOG     = 8;

    typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_WINDOW} rx_pattern_e;
    typedef enum int unsigned {FILL_UP, FILL_DOWN, FILL_SHUFFLED} fill_e;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 s_taken  = 1'b0;

    int unsigned fail_count;
    int unsigned waiting;
    int unsigned burst_left  = 0;
    int unsigned sent_count  = 0;
    int unsigned stall_span  = 0;
    int unsigned stall_phase = 0;
    rx_pattern_e stall_mode  = RX_ALWAYS;
    bit          freed_map [FRAME_COUNT_DEF];

    buddy_free_block_coalescer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    coalesce_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_span == 0) begin
            stall_mode <= rx_pattern_e'($urandom_range(0, 3));
            stall_span <= $urandom_range(40, 300);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
            default:   m_tready <= (stall_phase % 32 >= 24);
        endcase
    end

    task automatic release_frame(input int unsigned frame);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 30);
        end
        freed_map[frame] = 1'b1;
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_W'(frame);
        do @(negedge aclk); while (!s_taken);
        burst_left--;
        sent_count++;
    endtask

    task automatic release_region(input int unsigned base, input int unsigned span_log,
                                  input int unsigned keep, input fill_e fill);
        int unsigned frames [$];
        int unsigned j;
        int unsigned tmp;
        for (int unsigned i = 0; i < (1 << span_log); i++)
            frames.push_back(base + i);
        if (fill == FILL_DOWN)
            frames.reverse();
        if (fill == FILL_SHUFFLED) begin
            for (int i = frames.size() - 1; i > 0; i--) begin
                j         = $urandom_range(0, i);
                tmp       = frames[i];
                frames[i] = frames[j];
                frames[j] = tmp;
            end
        end
        for (int i = 0; i < keep && i < frames.size(); i++)
            release_frame(frames[i]);
    endtask

    initial begin
        int unsigned directed_frames [] = '{0, 1, 2, 3, 1, 0, 4, 6, 5, 7,
                                            2047, 2046, 1365, 1364, 682, 683};
        int unsigned random_end;
        int unsigned pick;
        int unsigned span_log;
        int unsigned base;
        bit          clean;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // merges, double frees and bit patterns, all in the lower half
        foreach (directed_frames[i])
            release_frame(directed_frames[i]);

        random_end = sent_count + RANDOM_ITEMS;
        while (sent_count < random_end) begin
            pick     = $urandom_range(0, 9);
            span_log = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
            base     = $urandom_range(0, (LOW_HALF >> span_log) - 1) << span_log;
            clean    = 1'b1;
            for (int unsigned i = 0; i < (1 << span_log); i++)
                if (freed_map[base + i])
                    clean = 1'b0;
            if (pick == 0 || !clean)
                release_frame($urandom_range(0, LOW_HALF - 1));
            else if (pick == 1)
                release_region(base, span_log, $urandom_range(1, 1 << span_log),
                               fill_e'($urandom_range(0, 2)));
            else
                release_region(base, span_log, 1 << span_log, fill_e'($urandom_range(0, 2)));
        end

        // untouched upper half block freed in random order must merge all the way up
        release_region(LOW_HALF, TAIL_LOG, 1 << TAIL_LOG, FILL_SHUFFLED);

        s_tvalid = 1'b0;
        while (waiting != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
